[rtl/core/positional_sequence_store_unit_assert.svh]
// Assertion macros shared by the positional sequence store.
`ifndef POSITIONAL_SEQUENCE_STORE_UNIT_ASSERT_SVH
`define POSITIONAL_SEQUENCE_STORE_UNIT_ASSERT_SVH

// Assert that a property holds on every clock edge outside reset.
`define PSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assert that a property holds on every clock edge, reset included.
`define PSS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/pss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_pkg
// Types and constants shared by the positional sequence store.
// ----------------------------------------------------------------------------
package pss_pkg;
   localparam int Capacity   = 64;
   localparam int DataWidth  = 32;
   localparam int AddrWidth  = $clog2(Capacity);
   localparam int CountWidth = $clog2(Capacity + 1);

   typedef enum logic [2:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_POP_FRONT  = 3'd1,
      MODE_INSERT     = 3'd2,
      MODE_REMOVE     = 3'd3,
      MODE_PUSH_BACK  = 3'd4,
      MODE_POP_BACK   = 3'd5,
      MODE_READ       = 3'd6,
      MODE_CLEAR      = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SHIFT = 4'b0010,
      ST_WRITE = 4'b0100,
      ST_READ  = 4'b1000
   } state_type;
endpackage

[rtl/core/positional_sequence_store_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_sequence_store_unit
// Ordered sequence of signed words kept in one synchronous memory.
// ----------------------------------------------------------------------------
// Channel   Direction  Ports
// req       in         req_valid, req_stall, req_mode, req_position, req_value
// rsp       out        rsp_valid, rsp_stall, rsp_read_value, rsp_count, rsp_status
//
// Each request takes one transfer in and gives one transfer out. Inserts and
// removes move the later entries through the single memory port, one read and
// write pair per entry. Inserts and pushes write the new value after the shift;
// clears, reads and failed requests move no entries. Reset clears only the
// count and control; memory contents are meaningless until written. A stalled
// response holds, and a new request is taken only after the response of the
// previous one has gone out of the output register or with it.
`include "positional_sequence_store_unit_assert.svh"

module positional_sequence_store_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [6:0]  req_position,
   input  logic signed [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_read_value,
   output logic [6:0]  rsp_count,
   output logic [1:0]  rsp_status
);
   localparam int AW = pss_pkg::AddrWidth;
   localparam int CW = pss_pkg::CountWidth;
   localparam int DW = pss_pkg::DataWidth;

   // The entry store. It is read and written in clocked blocks only.
   logic [DW-1:0] mem [pss_pkg::Capacity];
   logic [DW-1:0] rd_data_ff;

   pss_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;     // moving cursor during a shift
   logic [CW-1:0] stop_ff, stop_in;   // position where the shift ends
   logic          dir_up_ff, dir_up_in; // insert moves entries up
   logic [DW-1:0] val_ff, val_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_rd_ff, rsp_rd_in;
   logic [CW-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic [1:0]    rsp_st_ff, rsp_st_in;

   logic          mem_re, mem_we;
   logic [AW-1:0] mem_raddr, mem_waddr;
   logic [DW-1:0] mem_wdata;
   logic          shift_rd_ff, shift_rd_in; // read issued last cycle in shift

   logic          out_free, take;
   logic [CW-1:0] pos;
   pss_pkg::mode_type mode;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == pss_pkg::ST_IDLE) || !out_free;
   assign take      = req_valid && !req_stall;
   assign pos       = req_position[CW-1:0];
   assign mode      = pss_pkg::mode_type'(req_mode);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      stop_in      = stop_ff;
      dir_up_in    = dir_up_ff;
      val_in       = val_ff;
      shift_rd_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rd_in    = rsp_rd_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_st_in    = rsp_st_ff;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      mem_raddr    = idx_ff[AW-1:0];
      mem_waddr    = idx_ff[AW-1:0];
      mem_wdata    = rd_data_ff;

      case (state_ff)
         pss_pkg::ST_IDLE: begin
            if (take) begin
               rsp_rd_in  = '0;
               rsp_st_in  = pss_pkg::STATUS_OK;
               val_in     = req_value;
               case (mode)
                  pss_pkg::MODE_PUSH_FRONT, pss_pkg::MODE_INSERT,
                  pss_pkg::MODE_PUSH_BACK: begin
                     if (mode == pss_pkg::MODE_INSERT && req_position > 7'(count_ff)) begin
                        rsp_st_in = pss_pkg::STATUS_RANGE;
                     end else if (count_ff == CW'(pss_pkg::Capacity)) begin
                        rsp_st_in = pss_pkg::STATUS_FULL;
                     end
                     if (rsp_st_in != pss_pkg::STATUS_OK) begin
                        rsp_valid_in = 1'b1;
                        rsp_cnt_in   = count_ff;
                     end else begin
                        // Move entries from count-1 down to stop one up.
                        dir_up_in = 1'b1;
                        idx_in    = count_ff;
                        stop_in   = (mode == pss_pkg::MODE_PUSH_FRONT) ? '0 :
                                    (mode == pss_pkg::MODE_PUSH_BACK) ? count_ff : pos;
                        state_in  = pss_pkg::ST_SHIFT;
                     end
                  end
                  pss_pkg::MODE_POP_FRONT, pss_pkg::MODE_REMOVE,
                  pss_pkg::MODE_POP_BACK: begin
                     if (count_ff == '0 ||
                         (mode == pss_pkg::MODE_REMOVE && req_position >= 7'(count_ff))) begin
                        rsp_st_in    = pss_pkg::STATUS_RANGE;
                        rsp_valid_in = 1'b1;
                        rsp_cnt_in   = count_ff;
                     end else begin
                        dir_up_in = 1'b0;
                        idx_in    = (mode == pss_pkg::MODE_POP_FRONT) ? '0 :
                                    (mode == pss_pkg::MODE_POP_BACK) ? count_ff - 1'b1 : pos;
                        stop_in   = count_ff - 1'b1;
                        state_in  = pss_pkg::ST_SHIFT;
                     end
                  end
                  pss_pkg::MODE_READ: begin
                     if (req_position >= 7'(count_ff)) begin
                        rsp_st_in    = pss_pkg::STATUS_RANGE;
                        rsp_valid_in = 1'b1;
                        rsp_cnt_in   = count_ff;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = pos[AW-1:0];
                        state_in  = pss_pkg::ST_READ;
                     end
                  end
                  default: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_cnt_in   = '0;
                  end
               endcase
            end
         end
         pss_pkg::ST_SHIFT: begin
            // A read issued last cycle returns now; write it to its new place.
            if (shift_rd_ff) begin
               mem_we    = 1'b1;
               mem_waddr = dir_up_ff ? idx_ff[AW-1:0] : AW'(idx_ff - 1'b1);
            end else if (idx_ff == stop_ff) begin
               state_in = dir_up_ff ? pss_pkg::ST_WRITE : pss_pkg::ST_IDLE;
               if (!dir_up_ff) begin
                  count_in     = count_ff - 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_cnt_in   = count_ff - 1'b1;
               end
            end else begin
               mem_re      = 1'b1;
               shift_rd_in = 1'b1;
               if (dir_up_ff) begin
                  mem_raddr = AW'(idx_ff - 1'b1);
                  idx_in    = idx_ff - 1'b1;
               end else begin
                  mem_raddr = AW'(idx_ff + 1'b1);
                  idx_in    = idx_ff + 1'b1;
               end
            end
            if (shift_rd_ff && dir_up_ff) begin
               mem_waddr = AW'(idx_ff + 1'b1);
            end else if (shift_rd_ff) begin
               mem_waddr = AW'(idx_ff - 1'b1);
            end
         end
         pss_pkg::ST_WRITE: begin
            mem_we       = 1'b1;
            mem_waddr    = stop_ff[AW-1:0];
            mem_wdata    = val_ff;
            count_in     = count_ff + 1'b1;
            rsp_valid_in = 1'b1;
            rsp_cnt_in   = count_ff + 1'b1;
            state_in     = pss_pkg::ST_IDLE;
         end
         pss_pkg::ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_rd_in    = rd_data_ff;
            rsp_cnt_in   = count_ff;
            state_in     = pss_pkg::ST_IDLE;
         end
         default: begin
            state_in = pss_pkg::ST_IDLE;
         end
      endcase
   end

   // Payload registers; the response register is only loaded when free.
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      stop_ff   <= stop_in;
      dir_up_ff <= dir_up_in;
      val_ff    <= val_in;
      if (out_free) begin
         rsp_rd_ff  <= rsp_rd_in;
         rsp_cnt_ff <= rsp_cnt_in;
         rsp_st_ff  <= rsp_st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pss_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         shift_rd_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         shift_rd_ff  <= shift_rd_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_rd_ff;
   assign rsp_count      = 7'(rsp_cnt_ff);
   assign rsp_status     = rsp_st_ff;

   // The count never exceeds the capacity.
   `PSS_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(pss_pkg::Capacity), "count overflow")
   // A response that is stalled stays valid and keeps its count.
   `PSS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_count), "response dropped")
   // The count does not change on the step out of the read state.
   `PSS_ASSERT(a_count_change, clock, reset, !$stable(count_ff) |-> $past(state_ff) != pss_pkg::ST_READ, "count changed on read")
endmodule
